// ===== src/tvbb_pkg.sv =====
package tvbb_pkg;

	localparam int unsigned TIME_W = 48;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned REG_IDX_W = 3;

	localparam int unsigned FUEL_MIN_DWELL_US_DEF = 70000;
	localparam int unsigned OX_MIN_DWELL_US_DEF = 70000;
	localparam int unsigned AUX_MIN_DWELL_US_DEF = 70000;

	typedef enum logic [1:0] {
		MODE_ISOLATE  = 2'd0,
		MODE_OPEN     = 2'd1,
		MODE_REGULATE = 2'd2,
		MODE_HOLD     = 2'd3
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FUEL_UPPER = 3'd0,
		REG_FUEL_LOWER = 3'd1,
		REG_OX_UPPER   = 3'd2,
		REG_OX_LOWER   = 3'd3,
		REG_AUX_UPPER  = 3'd4,
		REG_AUX_LOWER  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [DATA_W-1:0] upper;
		logic [DATA_W-1:0] lower;
	} setpt_t;

endpackage

// ===== src/tvbb_cfg.sv =====
module tvbb_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tvbb_pkg::ADDR_W-1:0]   paddr,
	input  logic [tvbb_pkg::DATA_W-1:0]   pwdata,
	output logic [tvbb_pkg::DATA_W-1:0]   prdata,
	output tvbb_pkg::setpt_t              fuel_sp,
	output tvbb_pkg::setpt_t              ox_sp,
	output tvbb_pkg::setpt_t              aux_sp
);
	import tvbb_pkg::*;

	setpt_t   fuel_q, ox_q, aux_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fuel_q <= '0;
			ox_q   <= '0;
			aux_q  <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_FUEL_UPPER: fuel_q.upper <= pwdata;
				REG_FUEL_LOWER: fuel_q.lower <= pwdata;
				REG_OX_UPPER:   ox_q.upper   <= pwdata;
				REG_OX_LOWER:   ox_q.lower   <= pwdata;
				REG_AUX_UPPER:  aux_q.upper  <= pwdata;
				REG_AUX_LOWER:  aux_q.lower  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FUEL_UPPER: prdata = fuel_q.upper;
			REG_FUEL_LOWER: prdata = fuel_q.lower;
			REG_OX_UPPER:   prdata = ox_q.upper;
			REG_OX_LOWER:   prdata = ox_q.lower;
			REG_AUX_UPPER:  prdata = aux_q.upper;
			REG_AUX_LOWER:  prdata = aux_q.lower;
			default:        prdata = '0;
		endcase
	end

	assign fuel_sp = fuel_q;
	assign ox_sp   = ox_q;
	assign aux_sp  = aux_q;

endmodule

// ===== src/tvbb_valve.sv =====
module tvbb_valve #(
	parameter int unsigned DWELL_US = tvbb_pkg::FUEL_MIN_DWELL_US_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [tvbb_pkg::TIME_W-1:0] now_us,
	input  logic [tvbb_pkg::DATA_W-1:0] sample,
	input  tvbb_pkg::mode_t             mode,
	input  tvbb_pkg::setpt_t            sp,
	output logic                        valve_open
);
	import tvbb_pkg::*;

	localparam logic [TIME_W:0] DWELL_EXT = (TIME_W+1)'(DWELL_US);

	logic              intended_q;
	logic              valve_open_q;
	logic [TIME_W-1:0] last_change_q;
	logic              intended_d;
	logic              dwell_ok;
	logic              change;

	always_comb begin
		intended_d = intended_q;
		case (mode)
			MODE_ISOLATE:  intended_d = 1'b0;
			MODE_OPEN:     intended_d = 1'b1;
			MODE_REGULATE: begin
				// upper test wins when the setpoints cross
				if ($signed(sample) >= $signed(sp.upper))
					intended_d = 1'b0;
				else if ($signed(sample) <= $signed(sp.lower))
					intended_d = 1'b1;
			end
			default:       intended_d = intended_q;
		endcase
	end

	// sum carries one extra bit so it never wraps
	assign dwell_ok = {1'b0, now_us} >= ({1'b0, last_change_q} + DWELL_EXT);
	assign change   = dwell_ok & (valve_open_q != intended_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intended_q    <= 1'b0;
			valve_open_q  <= 1'b0;
			last_change_q <= '0;
		end else if (en) begin
			intended_q <= intended_d;
			if (change) begin
				valve_open_q  <= intended_d;
				last_change_q <= now_us;
			end
		end
	end

	assign valve_open = valve_open_q;

endmodule

// ===== src/three_valve_bang_bang_regulator.sv =====
// Three-valve bang-bang pressure regulator. Each accepted beat is one control
// tick carrying a 48-bit microsecond timestamp, one pressure sample and one mode
// per valve; it produces one beat with the three valve drive bits. A tick is
// captured in an input register and then evaluated into the valve state
// registers, which drive the result ports directly; while out_ready stays high
// one tick per cycle is sustained; a stalled output holds both. Each valve
// changes only after its minimum dwell (a module parameter) has elapsed since
// its last change. Setpoints are six signed 32-bit APB registers at byte
// addresses 0x00..0x14 (fuel upper/lower, ox upper/lower, aux upper/lower);
// write them only while the block is idle.
module three_valve_bang_bang_regulator #(
	parameter int unsigned FUEL_MIN_DWELL_US = tvbb_pkg::FUEL_MIN_DWELL_US_DEF,
	parameter int unsigned OX_MIN_DWELL_US   = tvbb_pkg::OX_MIN_DWELL_US_DEF,
	parameter int unsigned AUX_MIN_DWELL_US  = tvbb_pkg::AUX_MIN_DWELL_US_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [tvbb_pkg::TIME_W-1:0]        now_us,
	input  logic signed [tvbb_pkg::DATA_W-1:0] fuel_pressure_sample,
	input  logic signed [tvbb_pkg::DATA_W-1:0] ox_pressure_sample,
	input  logic signed [tvbb_pkg::DATA_W-1:0] aux_pressure_sample,
	input  logic [1:0]                         fuel_mode,
	input  logic [1:0]                         ox_mode,
	input  logic [1:0]                         aux_mode,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               fuel_valve_open,
	output logic                               ox_valve_open,
	output logic                               aux_valve_open,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tvbb_pkg::ADDR_W-1:0]        paddr,
	input  logic [tvbb_pkg::DATA_W-1:0]        pwdata,
	output logic [tvbb_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import tvbb_pkg::*;

	setpt_t            fuel_sp, ox_sp, aux_sp;
	logic              valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic [DATA_W-1:0] fuel_sample_s1, ox_sample_s1, aux_sample_s1;
	mode_t             fuel_mode_s1, ox_mode_s1, aux_mode_s1;
	logic              out_valid_q;
	logic              advance;

	assign pready = 1'b1;

	// valve state doubles as the result register, so stall it with the output
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1         <= now_us;
			fuel_sample_s1 <= fuel_pressure_sample;
			ox_sample_s1   <= ox_pressure_sample;
			aux_sample_s1  <= aux_pressure_sample;
			fuel_mode_s1   <= mode_t'(fuel_mode);
			ox_mode_s1     <= mode_t'(ox_mode);
			aux_mode_s1    <= mode_t'(aux_mode);
		end
	end

	assign out_valid = out_valid_q;

	tvbb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.fuel_sp (fuel_sp),
		.ox_sp   (ox_sp),
		.aux_sp  (aux_sp)
	);

	tvbb_valve #(.DWELL_US(FUEL_MIN_DWELL_US)) u_fuel (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.now_us     (now_s1),
		.sample     (fuel_sample_s1),
		.mode       (fuel_mode_s1),
		.sp         (fuel_sp),
		.valve_open (fuel_valve_open)
	);

	tvbb_valve #(.DWELL_US(OX_MIN_DWELL_US)) u_ox (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.now_us     (now_s1),
		.sample     (ox_sample_s1),
		.mode       (ox_mode_s1),
		.sp         (ox_sp),
		.valve_open (ox_valve_open)
	);

	tvbb_valve #(.DWELL_US(AUX_MIN_DWELL_US)) u_aux (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.now_us     (now_s1),
		.sample     (aux_sample_s1),
		.mode       (aux_mode_s1),
		.sp         (aux_sp),
		.valve_open (aux_valve_open)
	);

endmodule
